FILE: sv/cce_pkg.sv
package cce_pkg;

  // Longest escape sequence and size of the sequence table
  localparam int SEQ_MAX    = 7;
  localparam int TABLE_SIZE = 29;
  localparam int CODE_LIMIT = 28;
  localparam int CODE_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(SEQ_MAX + 1);

  localparam logic [7:0] AMP    = 8'h26;
  localparam logic [7:0] DIGIT0 = 8'h30;
  localparam logic [7:0] DIGIT9 = 8'h39;

  // Held partial code
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_AMP   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       msg_end_out;
  } out_t;

  // Bytes caused by one input transaction; entry 0 goes out first
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    msg_end;
  } run_t;

  function automatic logic [CNT_W-1:0] seq_len(input logic [CODE_W-1:0] code);
    logic [CNT_W-1:0] len;
    case (code)
      5'd0:                                                  len = 3'd6;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16: len = 3'd7;
      5'd28:                                                 len = 3'd7;
      5'd25, 5'd26:                                          len = 3'd4;
      default:                                               len = 3'd5;
    endcase
    return len;
  endfunction

  // Sequence text, first byte in the top byte lane
  function automatic logic [SEQ_MAX*8-1:0] seq_text(input logic [CODE_W-1:0] code);
    logic [SEQ_MAX*8-1:0] lit;
    case (code)
      5'd0:    lit = "\033[0;0m";
      5'd1:    lit = "\033[31m";
      5'd2:    lit = "\033[32m";
      5'd3:    lit = "\033[33m";
      5'd4:    lit = "\033[34m";
      5'd5:    lit = "\033[35m";
      5'd6:    lit = "\033[36m";
      5'd7:    lit = "\033[37m";
      5'd8:    lit = "\033[30m";
      5'd9:    lit = "\033[1;31m";
      5'd10:   lit = "\033[1;32m";
      5'd11:   lit = "\033[1;33m";
      5'd12:   lit = "\033[1;34m";
      5'd13:   lit = "\033[1;35m";
      5'd14:   lit = "\033[1;36m";
      5'd15:   lit = "\033[1;37m";
      5'd16:   lit = "\033[1;30m";
      5'd17:   lit = "\033[41m";
      5'd18:   lit = "\033[42m";
      5'd19:   lit = "\033[43m";
      5'd20:   lit = "\033[44m";
      5'd21:   lit = "\033[45m";
      5'd22:   lit = "\033[46m";
      5'd23:   lit = "\033[47m";
      5'd24:   lit = "\033[40m";
      5'd25:   lit = "\033[4m";
      5'd26:   lit = "\033[5m";
      5'd27:   lit = "\033[38m";
      5'd28:   lit = "\033[1;38m";
      default: lit = "\033[0;0m";
    endcase
    return lit << (8 * (SEQ_MAX - int'(seq_len(code))));
  endfunction

endpackage

FILE: sv/cce_parse.sv
module cce_parse import cce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  in_t   in_data,
  input  logic  color_enable,
  output run_t  run
);

  logic [1:0]              held_count;
  logic [3:0]              held_digit;
  logic [1:0]              held_count_next;
  logic [3:0]              held_digit_next;
  logic                    is_dig;
  logic                    is_amp;
  logic [7:0]              code_full;
  logic [CODE_W-1:0]       code_sel;
  logic [SEQ_MAX*8-1:0]    seq;
  logic [CNT_W-1:0]        len;
  logic                    flush_amp;
  logic                    flush_dig;
  logic                    take_b;
  logic [SEQ_MAX-1:0][7:0] run_bytes;
  logic [CNT_W-1:0]        n;

  assign is_dig = (in_data.in_byte >= DIGIT0) && (in_data.in_byte <= DIGIT9);
  assign is_amp = (in_data.in_byte == AMP);

  // Two-digit code: tens * 10 + units, out-of-range codes fall back to reset
  assign code_full = {1'b0, held_digit, 3'b000} + {3'b000, held_digit, 1'b0}
                     + {4'h0, in_data.in_byte[3:0]};
  assign code_sel  = (code_full > 8'(CODE_LIMIT) || code_full >= 8'(TABLE_SIZE))
                     ? '0 : code_full[CODE_W-1:0];
  assign seq = seq_text(code_sel);
  assign len = seq_len(code_sel);

  always_comb begin
    run_bytes       = '0;
    n               = '0;
    held_count_next = held_count;
    held_digit_next = held_digit;
    flush_amp       = 1'b0;
    flush_dig       = 1'b0;
    take_b          = 1'b0;
    case (held_count)
      HELD_AMP: begin
        if (is_dig) begin
          held_count_next = HELD_DIGIT;
          held_digit_next = in_data.in_byte[3:0];
        end else begin
          flush_amp = 1'b1;
          take_b    = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (is_dig) begin
          held_count_next = HELD_NONE;
          if (color_enable) begin
            for (int k = 0; k < SEQ_MAX; k++) begin
              run_bytes[k] = seq[8*(SEQ_MAX-1-k) +: 8];
            end
            n = len;
          end
        end else begin
          flush_amp = 1'b1;
          flush_dig = 1'b1;
          take_b    = 1'b1;
        end
      end
      default: take_b = 1'b1;
    endcase
    if (flush_amp) begin
      run_bytes[n] = AMP;
      n = n + 1'b1;
    end
    if (flush_dig) begin
      run_bytes[n] = DIGIT0 + {4'h0, held_digit};
      n = n + 1'b1;
    end
    if (take_b) begin
      if (is_amp) begin
        held_count_next = HELD_AMP;
      end else begin
        held_count_next = HELD_NONE;
        run_bytes[n] = in_data.in_byte;
        n = n + 1'b1;
      end
    end
    if (in_data.msg_end) begin
      if (held_count_next == HELD_AMP || held_count_next == HELD_DIGIT) begin
        run_bytes[n] = AMP;
        n = n + 1'b1;
      end
      if (held_count_next == HELD_DIGIT) begin
        run_bytes[n] = DIGIT0 + {4'h0, held_digit_next};
        n = n + 1'b1;
      end
      held_count_next = HELD_NONE;
    end
  end

  assign run.bytes   = run_bytes;
  assign run.count   = n;
  assign run.msg_end = in_data.msg_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
      held_digit <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

  a_held_legal: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held count reached an unused code");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.msg_end |=> held_count == HELD_NONE)
    else $error("partial code survived the end of a message");

endmodule

FILE: sv/cce_emit.sv
module cce_emit import cce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  run_t  run,
  input  logic  out_stall,
  output logic  out_valid,
  output out_t  out_data,
  output logic  free
);

  logic [SEQ_MAX-1:0][7:0] bytes;
  logic [CNT_W-1:0]        count;
  logic                    msg_end;
  logic                    take;

  assign out_valid = (count != '0);
  assign take      = out_valid && !out_stall;
  assign free      = (count == '0) || (count == CNT_W'(1) && take);

  assign out_data.out_byte    = bytes[0];
  assign out_data.run_end     = (count == CNT_W'(1));
  assign out_data.msg_end_out = (count == CNT_W'(1)) && msg_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run.count;
    end else if (take) begin
      count <= count - 1'b1;
    end
  end

  // Advance the byte queue towards lane 0
  always_ff @(posedge clk) begin
    if (load) begin
      bytes   <= run.bytes;
      msg_end <= run.msg_end;
    end else if (take) begin
      for (int k = 0; k < SEQ_MAX - 1; k++) begin
        bytes[k] <= bytes[k+1];
      end
      bytes[SEQ_MAX-1] <= '0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SEQ_MAX))
    else $error("byte count beyond the longest run");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (count == '0) || (count == CNT_W'(1) && !out_stall))
    else $error("new run loaded over bytes still to send");

endmodule

FILE: sv/color_code_expander.sv
// Colour code expander.
// Input channel (in_valid / in_stall / in_data) takes one text byte per
// transaction, with msg_end marking the last byte of a message. The output
// channel (out_valid / out_stall / out_data) returns the converted text one
// byte per transaction; run_end flags the last byte caused by an input
// transaction and msg_end_out the last byte of a message.
// A code '&' plus two digits becomes an escape sequence of 4 to 7 bytes, or
// nothing while colour is off (cfg_wen / cfg_wdata write the enable bit).
// Latency: an accepted byte appears at the output on the next cycle.
// Throughput: one input per cycle while each produces at most one byte and
// the output is not stalled; an input producing N bytes holds the output
// register until all N are taken, and the next input is taken in the cycle
// its last byte leaves. A partial code produces no byte.
// Reset: colour enabled, nothing held, output empty.
// Receiver stall: hold the current byte; in_stall rises until the run
// drains down to its final byte and that byte is taken.
module color_code_expander import cce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_wen,
  input  logic cfg_wdata
);

  logic color_enable;
  logic accept;
  logic free;
  run_t run;

  // Accept whenever the output side will be empty after this edge
  assign in_stall = !free;
  assign accept   = in_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_enable <= 1'b1;
    end else if (cfg_wen) begin
      color_enable <= cfg_wdata;
    end
  end

  // Decode the byte against the held partial code into a run of bytes
  cce_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .color_enable (color_enable),
    .run          (run)
  );

  // Send the run out one byte per transaction
  cce_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .run       (run),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

endmodule

FILE: tb/sv/tb_color_code_expander.sv
`timescale 1ns / 1ps

module tb_color_code_expander;
  import cce_pkg::*;

  // Run limits. The slowest legal run is about 210 bytes, each with a
  // sender gap and 7 result bytes that each wait out an output stall.
  // The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 170;
  localparam int CALM_FROM    = 135;
  localparam int SETTLE       = 4;
  localparam logic [7:0] ESC  = 8'h1B;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_wen;
  logic cfg_wdata;

  color_code_expander DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: our own copy of the colour enable and the held code.
  bit         colour_on;
  logic [1:0] held;
  logic [3:0] held_digit;

  // Bytes that one input transaction should produce, then the store of
  // every output transaction still awaited, oldest first.
  out_t run_bytes[$];
  out_t pending_bytes[$];

  // Directed rows. A typed row carries its expected text. The other rows
  // take their expected bytes from the predictor.
  in_t   row_item[$];
  bit    row_colour[$];
  bit    row_typed[$];
  string row_want[$];

  logic [7:0] message_text[$];

  int unsigned cycle_count;
  int errors;
  int items_sent;
  int results_seen;
  int colour_writes;
  int directed_count;
  bit calm;

  function automatic bit is_digit(input logic [7:0] b);
    return b >= DIGIT0 && b <= DIGIT9;
  endfunction

  // Escape body between "ESC[" and the closing 'm' for each colour code.
  function automatic string escape_body(input int code);
    case (code)
      1:  return "31";
      2:  return "32";
      3:  return "33";
      4:  return "34";
      5:  return "35";
      6:  return "36";
      7:  return "37";
      8:  return "30";
      9:  return "1;31";
      10: return "1;32";
      11: return "1;33";
      12: return "1;34";
      13: return "1;35";
      14: return "1;36";
      15: return "1;37";
      16: return "1;30";
      17: return "41";
      18: return "42";
      19: return "43";
      20: return "44";
      21: return "45";
      22: return "46";
      23: return "47";
      24: return "40";
      25: return "4";
      26: return "5";
      27: return "38";
      28: return "1;38";
      default: return "0;0";
    endcase
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    out_t o;
    if (run_bytes.size() >= SEQ_MAX) return;
    o.out_byte    = b;
    o.run_end     = 1'b0;
    o.msg_end_out = 1'b0;
    run_bytes.push_back(o);
  endfunction

  // Work out the output bytes that one accepted input byte causes.
  function automatic void expand_byte(input in_t item);
    logic [7:0] b;
    bit         fresh;
    int         code;
    string      seq;
    b     = item.in_byte;
    fresh = 1'b0;
    run_bytes.delete();

    case (held)
      HELD_AMP: begin
        if (is_digit(b)) begin
          held       = HELD_DIGIT;
          held_digit = 4'(b - DIGIT0);
        end else begin
          emit_byte(AMP);
          fresh = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (is_digit(b)) begin
          code = int'(held_digit) * 10 + int'(b - DIGIT0);
          held = HELD_NONE;
          if (code > CODE_LIMIT || code >= TABLE_SIZE) code = 0;
          if (colour_on) begin
            seq = {"[", escape_body(code), "m"};
            emit_byte(ESC);
            for (int k = 0; k < seq.len(); k++) emit_byte(seq[k]);
          end
        end else begin
          emit_byte(AMP);
          emit_byte(DIGIT0 + 8'(held_digit));
          fresh = 1'b1;
        end
      end
      // Treat anything else, including a count of three, as nothing held.
      default: fresh = 1'b1;
    endcase

    // Examine the breaking byte afresh: it may open a new code.
    if (fresh) begin
      if (b == AMP) begin
        held = HELD_AMP;
      end else begin
        held = HELD_NONE;
        emit_byte(b);
      end
    end

    // Flush a partial code at the end of the message.
    if (item.msg_end) begin
      if (held == HELD_AMP || held == HELD_DIGIT) emit_byte(AMP);
      if (held == HELD_DIGIT) emit_byte(DIGIT0 + 8'(held_digit));
      held = HELD_NONE;
    end

    if (run_bytes.size() > 0) begin
      run_bytes[run_bytes.size()-1].run_end     = 1'b1;
      run_bytes[run_bytes.size()-1].msg_end_out = item.msg_end;
    end
  endfunction

  function automatic void add_row(input bit colour, input logic [7:0] b, input bit msg_last,
                                  input bit typed, input string want);
    in_t item;
    item.in_byte = b;
    item.msg_end = msg_last;
    row_item.push_back(item);
    row_colour.push_back(colour);
    row_typed.push_back(typed);
    row_want.push_back(want);
  endfunction

  // Offer one byte with valid held high until the transaction is accepted.
  // Call at a falling edge. Return at the falling edge after acceptance
  // with valid still high, so that back-to-back bytes never toggle it.
  task automatic send_byte(input in_t item, input bit typed, input string want);
    out_t o;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_byte(item);
    if (typed) begin
      for (int k = 0; k < want.len(); k++) begin
        o.out_byte    = want[k];
        o.run_end     = (k == want.len() - 1);
        o.msg_end_out = o.run_end && item.msg_end;
        pending_bytes.push_back(o);
      end
    end else begin
      foreach (run_bytes[k]) pending_bytes.push_back(run_bytes[k]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 15));
  endtask

  // Stop the sender until every awaited byte is out. Then let the block
  // settle, in case a code byte was swallowed with no output.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_colour(input bit en);
    wait_drained();
    cfg_wdata <= en;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    colour_on = en;
    colour_writes++;
  endtask

  // Build one random message, mostly well-formed codes and text, with
  // broken codes, a partial code at the end, or raw noise now and then.
  task automatic compose_message();
    int target;
    int pick;
    int value;
    logic [7:0] b;
    message_text.delete();
    target = $urandom_range(1, 10);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) message_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    while (message_text.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        value = ($urandom_range(0, 4) != 0) ? $urandom_range(0, CODE_LIMIT)
                                            : $urandom_range(CODE_LIMIT + 1, 99);
        message_text.push_back(AMP);
        message_text.push_back(DIGIT0 + 8'(value / 10));
        message_text.push_back(DIGIT0 + 8'(value % 10));
      end else if (pick < 65) begin
        message_text.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        b = 8'($urandom_range(0, 255));
        if (is_digit(b)) b = AMP;
        message_text.push_back(AMP);
        if (pick >= 75) message_text.push_back(DIGIT0 + 8'($urandom_range(0, 9)));
        message_text.push_back(b);
      end else begin
        message_text.push_back(8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      message_text.push_back(AMP);
      if ($urandom_range(0, 1) == 1) message_text.push_back(DIGIT0 + 8'($urandom_range(0, 9)));
    end
  endtask

  // Stall the output side in random bursts, with calm stretches between.
  always begin
    @(negedge clk);
    if (!rst && !calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Check each accepted output transaction against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected output: expected none, got byte %h run_end %b msg_end_out %b",
                 $time, out_data.out_byte, out_data.run_end, out_data.msg_end_out);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_end !== want.run_end ||
            out_data.msg_end_out !== want.msg_end_out) begin
          $display("%0t: mismatch: expected byte %h run_end %b msg_end_out %b, got %h %b %b",
                   $time, want.out_byte, want.run_end, want.msg_end_out,
                   out_data.out_byte, out_data.run_end, out_data.msg_end_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still awaited", $time, pending_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wen       = 1'b0;
    cfg_wdata     = 1'b0;
    cycle_count   = 0;
    errors        = 0;
    items_sent    = 0;
    results_seen  = 0;
    colour_writes = 0;
    calm          = 1'b0;
    colour_on     = 1'b1;
    held          = HELD_NONE;
    held_digit    = '0;

    // Directed part, colour on: plain, zero and all-ones bytes, the lowest
    // and highest table codes, a code beyond the table, and codes broken
    // just below and just above the digit range.
    add_row(1, "A",   0, 1, "A");
    add_row(1, 8'h00, 0, 0, "");
    add_row(1, 8'hFF, 0, 0, "");
    add_row(1, AMP,   0, 1, "");
    add_row(1, "0",   0, 1, "");
    add_row(1, "0",   0, 1, "\033[0;0m");
    add_row(1, AMP,   0, 1, "");
    add_row(1, "2",   0, 1, "");
    add_row(1, "8",   0, 1, "\033[1;38m");
    add_row(1, AMP,   0, 1, "");
    add_row(1, "9",   0, 1, "");
    add_row(1, "9",   0, 1, "\033[0;0m");
    add_row(1, AMP,   0, 1, "");
    add_row(1, "/",   0, 1, "&/");
    add_row(1, AMP,   0, 1, "");
    add_row(1, "9",   0, 1, "");
    add_row(1, ":",   0, 1, "&9:");
    // A code broken by '&' at the end of a message: the new '&' is
    // flushed as well.
    add_row(1, AMP,   0, 1, "");
    add_row(1, "3",   0, 1, "");
    add_row(1, AMP,   1, 1, "&3&");
    add_row(1, AMP,   1, 1, "&");
    // Colour off: strip the code. The message ends with no output at all.
    add_row(0, AMP,   0, 1, "");
    add_row(0, "1",   0, 1, "");
    add_row(0, "2",   1, 1, "");
    add_row(0, "B",   1, 1, "B");

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (row_item[i]) begin
      if (row_colour[i] != colour_on) set_colour(row_colour[i]);
      maybe_gap();
      send_byte(row_item[i], row_typed[i], row_want[i]);
    end
    directed_count = items_sent;
    set_colour(1'b1);

    // Random part. Switch colour only between messages, with nothing held.
    while (items_sent < directed_count + RANDOM_ITEMS) begin
      if (items_sent >= directed_count + CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) set_colour($urandom_range(0, 1));
      else if (items_sent >= directed_count + RANDOM_ITEMS / 2 && colour_writes < 3)
        wait_drained();
      compose_message();
      foreach (message_text[k]) begin
        in_t item;
        item.in_byte = message_text[k];
        item.msg_end = (k == message_text.size() - 1);
        maybe_gap();
        send_byte(item, 1'b0, "");
      end
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d text bytes (%0d directed), checked %0d output bytes.",
             items_sent, directed_count, results_seen);
    $display("Colour enable written %0d times; codes, broken codes and noise covered.",
             colour_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
